// ===== hdl/bnps_pkg.sv =====
// Package for the Bezier nearest-point search block.
// Holds payload word types, the FSM state type and shared constants.
// No dependencies.
`default_nettype none

package bnps_pkg;

   localparam int STEPS_DEFAULT = 1024;
   localparam int COORD_W       = 24;
   localparam int INDEX_W       = 11;
   localparam int NUM_REGS      = 8;
   localparam int CSR_IDX_W     = 4;
   localparam int T_ONE         = 1024;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] snapped_x;
      logic signed [COORD_W-1:0] snapped_y;
      logic [INDEX_W-1:0]        sample_index;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/bnps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Used for the control point store. No dependencies.
`default_nettype none

module bnps_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/bezier_nearest_point_search.sv =====
// Top level of the Bezier nearest-point search block.
// Depends on bnps_pkg and bnps_ram.
// Usage:
//   Write the four control points (start, ctrl1, ctrl2, end; x then y,
//   indexes 0..7) through the csr_ channel while the block is idle. A write
//   to an index of 8 or more is dropped. All points read as 0 after reset.
//   Present a query point on the req_ channel; one word comes back on the
//   rsp_ channel with the nearest of the STEPS+1 curve samples and its index.
//   Ties go to the smaller index.
// Timing:
//   Per item the block fetches the control points, issues the STEPS + 1
//   samples at one a cycle into 10 pipeline stages, sees the pipeline empty
//   and loads the result register. It works on one query at a time.
//   The next query is accepted once the result is loaded, even while it waits
//   for rsp_ready; under a stall the block finishes that item and holds it.
// Reset:
//   Synchronous active-high reset clears the control state and marks all
//   control points as zero; no clearing pass is needed.
`default_nettype none

module bezier_nearest_point_search #(
   parameter int STEPS = bnps_pkg::STEPS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire bnps_pkg::req_word_type          req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output bnps_pkg::rsp_word_type               rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [bnps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bnps_pkg::COORD_W-1:0]    csr_data
);

   localparam int KW = $clog2(STEPS + 1);
   localparam int RW = $clog2(STEPS) + 1;
   localparam int TW = 11;
   localparam int NSTG = 10;
   localparam logic [TW-1:0] T_STEP = TW'(bnps_pkg::T_ONE / STEPS);
   localparam logic [RW-1:0] R_STEP = RW'(bnps_pkg::T_ONE % STEPS);
   localparam logic [RW-1:0] R_INIT = RW'(STEPS / 2);
   localparam logic [RW-1:0] R_MOD  = RW'(STEPS);
   localparam logic [KW-1:0] K_LAST = KW'(STEPS);
   localparam logic [TW-1:0] T_FULL = TW'(bnps_pkg::T_ONE);

   bnps_pkg::state_type state_ff, state_in;

   // control point store
   logic                           ram_we;
   logic [2:0]                     ram_rd_addr;
   logic [bnps_pkg::COORD_W-1:0]   ram_rd_data;
   logic [bnps_pkg::NUM_REGS-1:0]  pt_valid_ff;
   logic                           rd_valid_ff;
   logic [3:0]                     load_cnt_ff;
   logic signed [23:0]             coef_ff [bnps_pkg::NUM_REGS];
   logic signed [23:0]             qx_ff, qy_ff;

   // sample generator
   logic [KW-1:0] gen_k_ff;
   logic [TW-1:0] gen_t_ff;
   logic [RW-1:0] gen_r_ff;
   logic [RW-1:0] r_sum;

   // pipeline
   logic [NSTG-1:0]    v_ff;
   logic [KW-1:0]      k_pipe_ff [NSTG];
   logic [TW-1:0]      t0_ff, u0_ff, t1_ff, u1_ff;
   logic [20:0]        uu1_ff, tt1_ff, ut1_ff;
   logic [30:0]        w2_ff [4];
   logic signed [55:0] px3_ff [4], py3_ff [4];
   logic signed [55:0] sx4_ff [2], sy4_ff [2];
   logic signed [55:0] cx_ff [5:9], cy_ff [5:9];
   logic [54:0]        mx6_ff, my6_ff;
   logic [53:0]        hhx7_ff, hhy7_ff;
   logic [54:0]        hlx7_ff, hly7_ff;
   logic [55:0]        llx7_ff, lly7_ff;
   logic [109:0]       dx8_ff, dy8_ff;
   logic [110:0]       d9_ff;

   // best record and result
   logic               have_ff;
   logic [110:0]       best_d_ff;
   logic [KW-1:0]      best_k_ff;
   logic signed [55:0] best_x_ff, best_y_ff;
   logic               rsp_valid_ff;
   bnps_pkg::rsp_word_type rsp_data_ff;

   logic issue, load_rsp, start, take;
   logic signed [23:0] out_x, out_y;

   bnps_ram #(
      .WIDTH(bnps_pkg::COORD_W),
      .DEPTH(bnps_pkg::NUM_REGS)
   ) u_pt_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(csr_index[2:0]),
      .wr_data(csr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bnps_pkg::ST_IDLE:  if (req_valid) state_in = bnps_pkg::ST_LOAD;
         bnps_pkg::ST_LOAD:  if (load_cnt_ff == 4'd8) state_in = bnps_pkg::ST_RUN;
         bnps_pkg::ST_RUN:   if (gen_k_ff == K_LAST) state_in = bnps_pkg::ST_DRAIN;
         bnps_pkg::ST_DRAIN: if (v_ff == '0) state_in = bnps_pkg::ST_DONE;
         bnps_pkg::ST_DONE:  if (!rsp_valid_ff || rsp_ready) state_in = bnps_pkg::ST_IDLE;
         default:            state_in = bnps_pkg::ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_ready   = 1'b0;
      csr_ready   = 1'b0;
      issue       = 1'b0;
      load_rsp    = 1'b0;
      ram_rd_addr = load_cnt_ff[2:0];
      case (state_ff)
         bnps_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            csr_ready = 1'b1;
         end
         bnps_pkg::ST_RUN:  issue = 1'b1;
         bnps_pkg::ST_DONE: load_rsp = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign start  = req_valid && req_ready;
   assign ram_we = csr_valid && csr_ready && (csr_index < 4'(bnps_pkg::NUM_REGS));
   assign r_sum  = gen_r_ff + R_STEP;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= bnps_pkg::ST_IDLE;
         pt_valid_ff <= '0;
         v_ff        <= '0;
         have_ff     <= 1'b0;
         load_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (ram_we) begin
            pt_valid_ff[csr_index[2:0]] <= 1'b1;
         end
         v_ff <= {v_ff[NSTG-2:0], issue};
         if (start) begin
            load_cnt_ff <= '0;
            have_ff     <= 1'b0;
         end else if (state_ff == bnps_pkg::ST_LOAD) begin
            load_cnt_ff <= load_cnt_ff + 4'd1;
         end
         if (take) begin
            have_ff <= 1'b1;
         end
      end
   end

   // fetch control points; entries never written read as zero
   always_ff @(posedge clock) begin
      rd_valid_ff <= pt_valid_ff[ram_rd_addr];
      if (start) begin
         qx_ff <= req_data.point_x;
         qy_ff <= req_data.point_y;
      end
      if (state_ff == bnps_pkg::ST_LOAD && load_cnt_ff != 4'd0) begin
         coef_ff[3'(load_cnt_ff - 4'd1)] <= rd_valid_ff ? $signed(ram_rd_data) : 24'sd0;
      end
   end

   // sample generator: t(k) = round(k * 1024 / STEPS) kept as quotient and remainder
   always_ff @(posedge clock) begin
      if (state_ff == bnps_pkg::ST_LOAD) begin
         gen_k_ff <= '0;
         gen_t_ff <= '0;
         gen_r_ff <= R_INIT;
      end else if (issue) begin
         gen_k_ff <= gen_k_ff + KW'(1);
         if (r_sum >= R_MOD) begin
            gen_r_ff <= r_sum - R_MOD;
            gen_t_ff <= gen_t_ff + T_STEP + TW'(1);
         end else begin
            gen_r_ff <= r_sum;
            gen_t_ff <= gen_t_ff + T_STEP;
         end
      end
   end

   // datapath pipeline
   always_ff @(posedge clock) begin
      logic [31:0]        p_uuu, p_uut, p_utt, p_ttt;
      logic signed [55:0] diff_x, diff_y;
      // stage 0: grid point
      t0_ff        <= gen_t_ff;
      u0_ff        <= T_FULL - gen_t_ff;
      k_pipe_ff[0] <= gen_k_ff;
      for (int i = 1; i < NSTG; i++) begin
         k_pipe_ff[i] <= k_pipe_ff[i-1];
      end
      // stage 1: squares and cross term
      t1_ff  <= t0_ff;
      u1_ff  <= u0_ff;
      uu1_ff <= 21'(u0_ff * u0_ff);
      tt1_ff <= 21'(t0_ff * t0_ff);
      ut1_ff <= 21'(u0_ff * t0_ff);
      // stage 2: Bernstein weights
      p_uuu = 32'(uu1_ff) * 32'(u1_ff);
      p_uut = 32'(uu1_ff) * 32'(t1_ff);
      p_utt = 32'(ut1_ff) * 32'(t1_ff);
      p_ttt = 32'(tt1_ff) * 32'(t1_ff);
      w2_ff[0] <= p_uuu[30:0];
      w2_ff[1] <= 31'(p_uut + (p_uut << 1));
      w2_ff[2] <= 31'(p_utt + (p_utt << 1));
      w2_ff[3] <= p_ttt[30:0];
      // stage 3: weight times control coordinate
      for (int i = 0; i < 4; i++) begin
         px3_ff[i] <= $signed({1'b0, w2_ff[i]}) * coef_ff[2*i];
         py3_ff[i] <= $signed({1'b0, w2_ff[i]}) * coef_ff[2*i+1];
      end
      // stage 4, 5: sum of four terms
      sx4_ff[0] <= px3_ff[0] + px3_ff[1];
      sx4_ff[1] <= px3_ff[2] + px3_ff[3];
      sy4_ff[0] <= py3_ff[0] + py3_ff[1];
      sy4_ff[1] <= py3_ff[2] + py3_ff[3];
      cx_ff[5]  <= sx4_ff[0] + sx4_ff[1];
      cy_ff[5]  <= sy4_ff[0] + sy4_ff[1];
      for (int i = 6; i <= 9; i++) begin
         cx_ff[i] <= cx_ff[i-1];
         cy_ff[i] <= cy_ff[i-1];
      end
      // stage 6: offset magnitude against the query scaled by 2^30
      diff_x = cx_ff[5] - {{2{qx_ff[23]}}, qx_ff, 30'b0};
      diff_y = cy_ff[5] - {{2{qy_ff[23]}}, qy_ff, 30'b0};
      mx6_ff <= diff_x[55] ? 55'(-diff_x) : diff_x[54:0];
      my6_ff <= diff_y[55] ? 55'(-diff_y) : diff_y[54:0];
      // stage 7: partial products of the squares
      hhx7_ff <= mx6_ff[54:28] * mx6_ff[54:28];
      hlx7_ff <= 55'(mx6_ff[54:28] * mx6_ff[27:0]);
      llx7_ff <= mx6_ff[27:0] * mx6_ff[27:0];
      hhy7_ff <= my6_ff[54:28] * my6_ff[54:28];
      hly7_ff <= 55'(my6_ff[54:28] * my6_ff[27:0]);
      lly7_ff <= my6_ff[27:0] * my6_ff[27:0];
      // stage 8, 9: assemble squares and the distance
      dx8_ff <= {hhx7_ff, 56'b0} + {26'b0, hlx7_ff, 29'b0} + {54'b0, llx7_ff};
      dy8_ff <= {hhy7_ff, 56'b0} + {26'b0, hly7_ff, 29'b0} + {54'b0, lly7_ff};
      d9_ff  <= {1'b0, dx8_ff} + {1'b0, dy8_ff};
   end

   // keep the first strict minimum
   assign take = v_ff[NSTG-1] && (!have_ff || d9_ff < best_d_ff);

   always_ff @(posedge clock) begin
      if (take) begin
         best_d_ff <= d9_ff;
         best_k_ff <= k_pipe_ff[NSTG-1];
         best_x_ff <= cx_ff[9];
         best_y_ff <= cy_ff[9];
      end
   end

   // round to nearest, ties up, then saturate
   always_comb begin
      logic signed [56:0] bx, by;
      logic signed [26:0] rx, ry;
      bx = 57'(best_x_ff) + 57'sd536870912;
      by = 57'(best_y_ff) + 57'sd536870912;
      rx = 27'(bx >>> 30);
      ry = 27'(by >>> 30);
      if (rx > 27'sd8388607)       out_x = 24'sd8388607;
      else if (rx < -27'sd8388608) out_x = -24'sd8388608;
      else                         out_x = rx[23:0];
      if (ry > 27'sd8388607)       out_y = 24'sd8388607;
      else if (ry < -27'sd8388608) out_y = -24'sd8388608;
      else                         out_y = ry[23:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_rsp) begin
         rsp_data_ff.snapped_x    <= out_x;
         rsp_data_ff.snapped_y    <= out_y;
         rsp_data_ff.sample_index <= bnps_pkg::INDEX_W'(best_k_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_cmp_in_run: assert property (@(posedge clock) disable iff (reset)
      v_ff[NSTG-1] |-> (state_ff == bnps_pkg::ST_RUN || state_ff == bnps_pkg::ST_DRAIN))
      else $error("compare stage active outside a search");

   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == bnps_pkg::ST_DONE |-> (v_ff == '0 && have_ff))
      else $error("result taken before the pipeline drained");

   a_best_range: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> best_k_ff <= K_LAST)
      else $error("chosen sample index beyond the grid");

   a_csr_mark: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> pt_valid_ff[$past(csr_index[2:0])])
      else $error("written control point not marked");
`endif

endmodule

`default_nettype wire

// ===== test/bezier_nearest_point_search_test.sv =====
// Self-checking testbench for the Bezier nearest-point search block.
// Depends on bnps_pkg and the bezier_nearest_point_search RTL.
// Drives query words, predicts each snapped sample and compares every response.
`timescale 1ns / 100ps
`default_nettype none

module bezier_nearest_point_search_test;

   localparam int STEPS       = bnps_pkg::STEPS_DEFAULT;
   localparam int RANDOM_SETS = 8;
   localparam int SET_ITEMS   = 71;
   localparam int SETTLE      = STEPS + 40;
   localparam longint CYCLE_LIMIT = 3000000;

   localparam logic [bnps_pkg::CSR_IDX_W-1:0] REG_START_X = 0;
   localparam logic [bnps_pkg::CSR_IDX_W-1:0] REG_START_Y = 1;
   localparam logic [bnps_pkg::CSR_IDX_W-1:0] REG_CTRL1_X = 2;
   localparam logic [bnps_pkg::CSR_IDX_W-1:0] REG_CTRL1_Y = 3;
   localparam logic [bnps_pkg::CSR_IDX_W-1:0] REG_CTRL2_X = 4;
   localparam logic [bnps_pkg::CSR_IDX_W-1:0] REG_CTRL2_Y = 5;
   localparam logic [bnps_pkg::CSR_IDX_W-1:0] REG_END_X   = 6;
   localparam logic [bnps_pkg::CSR_IDX_W-1:0] REG_END_Y   = 7;
   localparam logic [bnps_pkg::CSR_IDX_W-1:0] REG_UNUSED  = 8;
   localparam logic [bnps_pkg::CSR_IDX_W-1:0] REG_TOP     = 15;

   localparam logic signed [bnps_pkg::COORD_W-1:0] C_MAX = 24'sh7FFFFF;
   localparam logic signed [bnps_pkg::COORD_W-1:0] C_MIN = 24'sh800000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   bnps_pkg::req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   bnps_pkg::rsp_word_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [bnps_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bnps_pkg::COORD_W-1:0] csr_data = '0;

   logic quiet = 0;
   logic hold = 0;
   int errors = 0;
   longint cycles = 0;

   logic signed [bnps_pkg::COORD_W-1:0] curve_reg [bnps_pkg::NUM_REGS];
   bnps_pkg::req_word_type pending_points [$];
   bnps_pkg::rsp_word_type expected_snaps [$];

   bezier_nearest_point_search #(.STEPS(STEPS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // Curve coordinate at grid index k, units of 2^-30.
   function automatic longint curve_at(int k, int axis);
      longint t, u;
      longint tq;
      tq = (longint'(k) * bnps_pkg::T_ONE + STEPS / 2) / STEPS;
      t = (tq > bnps_pkg::T_ONE) ? bnps_pkg::T_ONE : tq;
      u = bnps_pkg::T_ONE - t;
      return u * u * u * longint'(curve_reg[axis])
           + 3 * u * u * t * longint'(curve_reg[2 + axis])
           + 3 * u * t * t * longint'(curve_reg[4 + axis])
           + t * t * t * longint'(curve_reg[6 + axis]);
   endfunction

   function automatic logic signed [bnps_pkg::COORD_W-1:0] round_coord(longint v);
      longint r;
      r = (v + (longint'(1) <<< 29)) >>> 30;
      if (r > 8388607) r = 8388607;
      if (r < -8388608) r = -8388608;
      return r[bnps_pkg::COORD_W-1:0];
   endfunction

   function automatic bnps_pkg::rsp_word_type nearest_sample(bnps_pkg::req_word_type q);
      longint qx, qy, cx, cy, dx, dy, bx, by;
      logic [127:0] ax, ay, sq_dist, best;
      int best_k;
      bnps_pkg::rsp_word_type r;
      qx = longint'(q.point_x) <<< 30;
      qy = longint'(q.point_y) <<< 30;
      best = '0;
      best_k = 0;
      bx = 0;
      by = 0;
      for (int k = 0; k <= STEPS; k++) begin
         cx = curve_at(k, 0);
         cy = curve_at(k, 1);
         dx = cx - qx;
         dy = cy - qy;
         ax = (dx < 0) ? 128'(-dx) : 128'(dx);
         ay = (dy < 0) ? 128'(-dy) : 128'(dy);
         sq_dist = ax * ax + ay * ay;
         if (k == 0 || sq_dist < best) begin
            best = sq_dist;
            best_k = k;
            bx = cx;
            by = cy;
         end
      end
      r.snapped_x = round_coord(bx);
      r.snapped_y = round_coord(by);
      r.sample_index = best_k[bnps_pkg::INDEX_W-1:0];
      return r;
   endfunction

   // Query sender: pop a word when the slot is free, idle at random.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_snaps.push_back(nearest_sample(req_data));
         if (!req_valid || req_ready) begin
            if (pending_points.size() > 0 && (quiet || $urandom_range(99) >= 16)) begin
               req_data <= pending_points.pop_front();
               req_valid <= 1;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // Response checker.
   always @(posedge clock) begin
      bnps_pkg::rsp_word_type want;
      cycles <= cycles + 1;
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         rsp_ready <= !hold && (quiet || $urandom_range(99) >= 16);
         if (rsp_valid && rsp_ready) begin
            if (expected_snaps.size() == 0) begin
               $error("unexpected response word %h", rsp_data);
               errors++;
            end else begin
               want = expected_snaps.pop_front();
               if (rsp_data.snapped_x !== want.snapped_x) begin
                  $error("snapped_x expected %0d actual %0d", want.snapped_x,
                         rsp_data.snapped_x);
                  errors++;
               end
               if (rsp_data.snapped_y !== want.snapped_y) begin
                  $error("snapped_y expected %0d actual %0d", want.snapped_y,
                         rsp_data.snapped_y);
                  errors++;
               end
               if (rsp_data.sample_index !== want.sample_index) begin
                  $error("sample_index expected %0d actual %0d", want.sample_index,
                         rsp_data.sample_index);
                  errors++;
               end
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic write_reg(logic [bnps_pkg::CSR_IDX_W-1:0] idx,
                            logic [bnps_pkg::COORD_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx < bnps_pkg::NUM_REGS)
         curve_reg[idx] = value;
   endtask

   task automatic write_curve(logic [bnps_pkg::COORD_W-1:0] sx, sy, c1x, c1y, c2x, c2y,
                              ex, ey);
      write_reg(REG_START_X, sx);
      write_reg(REG_START_Y, sy);
      write_reg(REG_CTRL1_X, c1x);
      write_reg(REG_CTRL1_Y, c1y);
      write_reg(REG_CTRL2_X, c2x);
      write_reg(REG_CTRL2_Y, c2y);
      write_reg(REG_END_X, ex);
      write_reg(REG_END_Y, ey);
   endtask

   task automatic add_point(logic [bnps_pkg::COORD_W-1:0] x,
                            logic [bnps_pkg::COORD_W-1:0] y);
      bnps_pkg::req_word_type p;
      p.point_x = x;
      p.point_y = y;
      pending_points.push_back(p);
   endtask

   function automatic logic [bnps_pkg::COORD_W-1:0] near_coord(int axis);
      longint v;
      v = longint'(curve_reg[2 * $urandom_range(3) + axis]) + $urandom_range(8191) - 4096;
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v[bnps_pkg::COORD_W-1:0];
   endfunction

   task automatic drain();
      while (pending_points.size() > 0 || req_valid || expected_snaps.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < bnps_pkg::NUM_REGS; i++)
         curve_reg[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 0;

      // Degenerate curve after reset: every sample ties, index 0 wins.
      add_point(C_MAX, C_MAX);
      add_point(C_MIN, C_MIN);
      add_point(0, 0);
      drain();

      // Full-span curve with field extremes, ends, ties and dropped writes.
      write_curve(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX);
      write_reg(REG_UNUSED, 24'h123456);
      write_reg(REG_TOP, 24'hFFFFFF);
      add_point(C_MIN, C_MIN);
      add_point(C_MAX, C_MAX);
      add_point(C_MAX, C_MIN);
      add_point(C_MIN, C_MAX);
      add_point(0, 0);
      add_point(24'h000001, 24'hFFFFFF);
      drain();

      // Straight line: queries above and below the same sample, and at the end point.
      write_curve(0, 0, 24'h000100, 0, 24'h000200, 0, 24'h000300, 0);
      add_point(24'h000180, 24'h001000);
      add_point(24'h000180, 24'hFFF000);
      add_point(24'h000300, 0);
      drain();

      for (int s = 0; s < RANDOM_SETS; s++) begin
         if (s == RANDOM_SETS - 1)
            write_curve(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
         else
            for (int r = 0; r < bnps_pkg::NUM_REGS; r++)
               write_reg(r[bnps_pkg::CSR_IDX_W-1:0], 24'($urandom));
         quiet <= (s == 2);
         for (int i = 0; i < SET_ITEMS; i++)
            if ($urandom_range(1))
               add_point(near_coord(0), near_coord(1));
            else
               add_point(24'($urandom), 24'($urandom));
         if (s == 4) begin
            // stall the response side so the block fills and blocks queries
            hold <= 1;
            repeat (6000) @(posedge clock);
            hold <= 0;
         end
         drain();
      end

      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/bnps_pkg.sv
hdl/bnps_ram.sv
hdl/bezier_nearest_point_search.sv
test/bezier_nearest_point_search_test.sv
